>>> src/wetm_pkg.sv
// Shared constants and types for the windowed error trend monitor.
package wetm_pkg;

  localparam int unsigned WINDOW  = 16;
  localparam int unsigned HALF    = WINDOW / 2;
  localparam int unsigned ErrW    = 24;
  localparam int unsigned PtrW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FillW   = $clog2(WINDOW + 1);
  // half-window sum of HALF entries of ErrW bits
  localparam int unsigned SumW    = ErrW + $clog2(HALF + 1);
  localparam int unsigned DeclW   = SumW + 1;
  localparam int unsigned OutDeclW = 28;
  localparam int unsigned OneQ16  = 65536;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 32;

  // decline shown before the windows fill: 1.0 * HALF in signed Q13.16
  localparam logic [DeclW-1:0] DeclPreset = DeclW'(OneQ16 * HALF);

  // register byte addresses
  localparam logic [CfgAddrW-1:0] RegThreshold = CfgAddrW'(0);

  // one memory word holds both errors of one item
  typedef struct packed {
    logic [ErrW-1:0] train;
    logic [ErrW-1:0] valid;
  } win_word_t;

endpackage

>>> src/windowed_error_trend_monitor.sv
// Windowed error trend monitor: sliding error windows, running half sums, convergence flag.

// Takes one item per cycle while the output is not stalled and returns one result item per
// input item via the stage 1, stage 2 and output registers; an output stall holds the whole
// pipeline, and an input item is taken whenever the output register is empty or is being
// emptied. Both errors of an item share one word of a WINDOW-deep memory with one write
// port and two registered read ports: the entries at age HALF-1 and age 2*HALF-1 are read
// while the new item is written, the half sums are updated in the next stage, and the
// decline and convergence rule are evaluated from the sum registers in the last stage.
// Window slots not yet written count as zero, gated by the fill count. Until WINDOW items
// have been pushed the decline reads 1.0 * HALF. decline_threshold sits at byte address 0
// of the APB port and should only be written while no item is in flight.
module windowed_error_trend_monitor
  import wetm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CfgAddrW-1:0]   paddr,
  input  logic [CfgDataW-1:0]   pwdata,
  output logic [CfgDataW-1:0]   prdata,
  output logic                  pready,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ErrW-1:0]       valid_error_i,
  input  logic [ErrW-1:0]       train_error_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  converged_o,
  output logic                  window_full_o,
  output logic signed [OutDeclW-1:0] valid_decline_sum_o
);

  // configuration register
  logic [ErrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == RegThreshold)) begin
      thr_q <= pwdata[ErrW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegThreshold) ? CfgDataW'(thr_q) : '0;

  // pipeline control: every stage moves when the output register can take a new item
  logic advance;
  logic in_acc;
  logic out_valid_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign in_acc     = in_valid_i && advance;

  // stage 0: write pointer, fill count, memory access
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [PtrW:0]    mid_sum, end_sum;
  logic [PtrW-1:0]  mid_addr, end_addr;

  always_comb begin
    mid_sum  = (PtrW+1)'(wr_ptr_q) + (PtrW+1)'(WINDOW - HALF);
    end_sum  = (PtrW+1)'(wr_ptr_q) + (PtrW+1)'(WINDOW - 2 * HALF);
    mid_addr = (mid_sum >= (PtrW+1)'(WINDOW)) ? PtrW'(mid_sum - (PtrW+1)'(WINDOW))
                                              : PtrW'(mid_sum);
    end_addr = (end_sum >= (PtrW+1)'(WINDOW)) ? PtrW'(end_sum - (PtrW+1)'(WINDOW))
                                              : PtrW'(end_sum);
    wr_ptr_d = (wr_ptr_q == PtrW'(WINDOW - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    fill_d   = (fill_q < FillW'(WINDOW)) ? fill_q + FillW'(1) : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else if (in_acc) begin
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  win_word_t win_mem [WINDOW];
  win_word_t mid_rd_q, end_rd_q;

  // read-before-write: the end slot equals the write slot for an even window
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mid_rd_q               <= win_mem[mid_addr];
      end_rd_q               <= win_mem[end_addr];
      win_mem[wr_ptr_q]      <= '{train: train_error_i, valid: valid_error_i};
    end
  end

  // stage 1 registers
  logic            s1_valid_q;
  logic [ErrW-1:0] s1_v_q, s1_t_q;
  logic            s1_mid_ok_q, s1_end_ok_q, s1_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_v_q      <= valid_error_i;
      s1_t_q      <= train_error_i;
      s1_mid_ok_q <= (fill_q >= FillW'(HALF));
      s1_end_ok_q <= (fill_q >= FillW'(2 * HALF));
      s1_full_q   <= (fill_d == FillW'(WINDOW));
    end
  end

  // stage 1: running half sums
  logic [SumW-1:0] vn_q, vo_q, tn_q, to_q;
  logic [SumW-1:0] vn_d, vo_d, tn_d, to_d;
  logic [ErrW-1:0] v_mid, v_end, t_mid, t_end;
  logic            s1_go;

  assign s1_go = advance && s1_valid_q;

  always_comb begin
    v_mid = s1_mid_ok_q ? mid_rd_q.valid : '0;
    t_mid = s1_mid_ok_q ? mid_rd_q.train : '0;
    v_end = s1_end_ok_q ? end_rd_q.valid : '0;
    t_end = s1_end_ok_q ? end_rd_q.train : '0;
    // entry at age HALF-1 moves to the older half, age 2*HALF-1 leaves it
    vn_d  = vn_q + SumW'(s1_v_q) - SumW'(v_mid);
    vo_d  = vo_q + SumW'(v_mid)  - SumW'(v_end);
    tn_d  = tn_q + SumW'(s1_t_q) - SumW'(t_mid);
    to_d  = to_q + SumW'(t_mid)  - SumW'(t_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= '0;
      vo_q <= '0;
      tn_q <= '0;
      to_q <= '0;
    end else if (s1_go) begin
      vn_q <= vn_d;
      vo_q <= vo_d;
      tn_q <= tn_d;
      to_q <= to_d;
    end
  end

  // stage 2 registers
  logic s2_valid_q, s2_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_full_q <= s1_full_q;
    end
  end

  // stage 2: decline and convergence rule from the updated sums
  logic signed [DeclW-1:0] decl;
  logic [SumW-1:0]         thr_scaled;
  logic                    train_neg, conv;

  always_comb begin
    if (s2_full_q) begin
      decl = $signed({1'b0, vo_q}) - $signed({1'b0, vn_q});
    end else begin
      decl = $signed(DeclPreset);
    end
    train_neg  = s2_full_q && (to_q < tn_q);
    thr_scaled = SumW'(thr_q) * SumW'(HALF);
    if (!decl[DeclW-1]) begin
      conv = decl[SumW-1:0] < thr_scaled;
    end else begin
      conv = train_neg;
    end
  end

  logic                       conv_q, full_q;
  logic signed [OutDeclW-1:0] decl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      conv_q <= conv;
      full_q <= s2_full_q;
      decl_q <= OutDeclW'(decl);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign converged_o         = conv_q;
  assign window_full_o       = full_q;
  assign valid_decline_sum_o = decl_q;

  // fill count saturates at the window depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW))
    else $error("fill count beyond window depth");

  // an accepted item below full bumps the fill count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (fill_q < FillW'(WINDOW)) |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("fill count did not advance");

  // a full window reported means the fill count has saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && full_q |-> fill_q == FillW'(WINDOW))
    else $error("window reported full too early");

  // before the window fills, the decline shows the preset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !full_q |-> decl_q == OutDeclW'(DeclPreset))
    else $error("preset decline not shown while filling");

endmodule

>>> bench/tb_top.sv
// Testbench for the windowed error trend monitor: directed and random error sequences.
`timescale 1ns / 1ps

module tb_top;
  import wetm_pkg::*;

  localparam longint HalfL = HALF;
  localparam logic [ErrW-1:0] MaxErr = {ErrW{1'b1}};
  localparam logic [CfgAddrW-1:0] RegUnmapped = CfgAddrW'(1);
  localparam int unsigned PipeDepth = 4;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PhaseItems = 230;

  typedef struct packed {
    logic                conv;
    logic                full;
    logic [OutDeclW-1:0] decl;
  } trend_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ErrW-1:0] valid_err = '0;
  logic [ErrW-1:0] train_err = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic converged;
  logic window_full;
  logic signed [OutDeclW-1:0] decline;

  // trend predictor state
  logic [ErrW-1:0] hist_valid [WINDOW];
  logic [ErrW-1:0] hist_train [WINDOW];
  int unsigned fill_cnt = 0;
  int unsigned wr_slot = 0;
  longint valid_newer = 0;
  longint valid_older = 0;
  longint train_newer = 0;
  longint train_older = 0;
  logic [ErrW-1:0] decline_threshold = '0;

  trend_result_t trend_q [$];
  int error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  windowed_error_trend_monitor u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .valid_error_i       (valid_err),
    .train_error_i       (train_err),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .converged_o         (converged),
    .window_full_o       (window_full),
    .valid_decline_sum_o (decline)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      hist_valid[i] = '0;
      hist_train[i] = '0;
    end
  end

  // push one pair into the windows and work out the flag and decline
  function automatic trend_result_t predict_trend(input logic [ErrW-1:0] v,
                                                  input logic [ErrW-1:0] t);
    int unsigned mid;
    int unsigned last;
    longint vm;
    longint tm;
    longint ve;
    longint te;
    longint vd;
    longint td;
    trend_result_t r;
    mid  = (wr_slot + WINDOW - 1 - (HALF - 1)) % WINDOW;
    last = (wr_slot + WINDOW - 1 - (2 * HALF - 1)) % WINDOW;
    vm = hist_valid[mid];
    tm = hist_train[mid];
    ve = hist_valid[last];
    te = hist_train[last];
    // entry at age HALF-1 crosses into the older half, oldest one drops out
    valid_newer = valid_newer + longint'(v) - vm;
    valid_older = valid_older + vm - ve;
    train_newer = train_newer + longint'(t) - tm;
    train_older = train_older + tm - te;
    hist_valid[wr_slot] = v;
    hist_train[wr_slot] = t;
    wr_slot = (wr_slot + 1) % WINDOW;
    if (fill_cnt < WINDOW) fill_cnt++;
    r.full = (fill_cnt == WINDOW);
    if (r.full) begin
      vd = valid_older - valid_newer;
      td = train_older - train_newer;
    end else begin
      vd = longint'(OneQ16) * HalfL;
      td = vd;
    end
    if (vd >= 0) r.conv = (vd < longint'(decline_threshold) * HalfL);
    else r.conv = (td < 0);
    r.decl = vd[OutDeclW-1:0];
    return r;
  endfunction

  function automatic logic [ErrW-1:0] clamp_err(input longint x);
    if (x < 0) return '0;
    if (x > longint'(MaxErr)) return MaxErr;
    return x[ErrW-1:0];
  endfunction

  function automatic logic [ErrW-1:0] corner_err();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return MaxErr;
      2: return 24'h800000;
      3: return 24'h7FFFFF;
      default: return 24'h000001;
    endcase
  endfunction

  task automatic push_errors(input logic [ErrW-1:0] v, input logic [ErrW-1:0] t);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    valid_err <= v;
    train_err <= t;
    do @(posedge clk); while (!in_ready);
    trend_q.push_back(predict_trend(v, t));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (trend_q.size() != 0) @(posedge clk);
    repeat (PipeDepth) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] addr,
                                input logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RegThreshold) decline_threshold = data[ErrW-1:0];
    // the bus goes idle before the next transfer
    @(posedge clk);
  endtask

  // well-formed trends dominate; full-range noise and corner values fill the rest
  task automatic run_segment(input int unsigned n);
    int unsigned mode;
    longint mag;
    longint nmag;
    longint bv;
    longint bt;
    longint sv;
    longint st;
    logic [ErrW-1:0] v;
    logic [ErrW-1:0] t;
    mode = $urandom_range(0, 5);
    mag  = longint'(1) << $urandom_range(2, 18);
    nmag = longint'(1) << $urandom_range(0, 16);
    bv = $urandom_range(0, MaxErr);
    bt = $urandom_range(0, MaxErr);
    sv = longint'($urandom_range(0, 2 * mag)) - mag;
    st = ($urandom_range(0, 1) != 0) ? sv : longint'($urandom_range(0, 2 * mag)) - mag;
    repeat (n) begin
      case (mode)
        0: begin
          v = ErrW'($urandom);
          t = ErrW'($urandom);
        end
        1: begin
          v = corner_err();
          t = corner_err();
        end
        default: begin
          bv = bv + sv + longint'($urandom_range(0, nmag)) - nmag / 2;
          bt = bt + st + longint'($urandom_range(0, nmag)) - nmag / 2;
          v = clamp_err(bv);
          t = clamp_err(bt);
        end
      endcase
      push_errors(v, t);
    end
  endtask

  // fill phase: decline preset to 1.0 * HALF, flag set only for threshold above 1.0
  task automatic test_fill_phase();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_register(RegThreshold, 32'hA501_0001);
    for (int k = 0; k < 8; k++) push_errors(MaxErr, ErrW'(k));
    wait_quiet();
    write_register(RegThreshold, 32'h0001_0000);
    // no register at this address: threshold must stay put
    write_register(RegUnmapped, 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) push_errors('0, MaxErr);
    wait_quiet();
  endtask

  // largest declines of both signs, zero decline, decline equal to the threshold bound
  task automatic test_decline_extremes();
    write_register(RegThreshold, 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) push_errors(MaxErr, (k < 4) ? MaxErr : '0);
    for (int k = 0; k < 8; k++) push_errors('0, MaxErr);
    wait_quiet();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_cycles = 80;
    run_segment(40);
    wait_quiet();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_trends();
    logic [ErrW-1:0] thr;
    int unsigned sent;
    int unsigned n;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: thr = '0;
        1: thr = MaxErr;
        2: thr = ErrW'($urandom_range(0, 1 << 16));
        3: thr = ErrW'($urandom_range(0, 1 << 20));
        4: thr = 24'h000001;
        5: thr = ErrW'($urandom);
        default: thr = ErrW'($urandom_range(0, 1 << 18));
      endcase
      write_register(RegThreshold, {8'($urandom), thr});
      sent = 0;
      while (sent < PhaseItems) begin
        n = $urandom_range(8, 40);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        run_segment(n);
        sent += n;
      end
      wait_quiet();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_phase();
    test_decline_extremes();
    test_backpressure();
    test_random_trends();
    wait_quiet();
    repeat (2 * PipeDepth) @(posedge clk);
    if (error_count == 0) begin
      $display("[windowed_error_trend_monitor] OK");
    end else begin
      $display("[windowed_error_trend_monitor] ERROR");
    end
    $finish;
  end

  // result side: random stalls per item, one long hold on request
  initial begin : result_sink
    int unsigned pause;
    forever begin
      if (hold_cycles != 0) begin
        pause = hold_cycles;
        hold_cycles = 0;
      end else begin
        pause = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    trend_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (trend_q.size() == 0) begin
        $display("%0t unexpected item: converged %0b window_full %0b decline %0h",
                 $time, converged, window_full, decline);
        error_count++;
      end else begin
        want = trend_q.pop_front();
        if (converged !== want.conv) begin
          $display("%0t converged mismatch: expected %0b actual %0b",
                   $time, want.conv, converged);
          error_count++;
        end
        if (window_full !== want.full) begin
          $display("%0t window_full mismatch: expected %0b actual %0b",
                   $time, want.full, window_full);
          error_count++;
        end
        if (decline !== want.decl) begin
          $display("%0t valid_decline_sum mismatch: expected %0h actual %0h",
                   $time, want.decl, decline);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t no item moved for %0d cycles", $time, stall_cycles);
      $display("[windowed_error_trend_monitor] ERROR");
      $finish;
    end
  end

endmodule
